// ----- hdl/fwcb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fwcb_pkg;

  // program block geometry (power of two, eight bytes at most)
  localparam int BLOCK_BYTES = 8;
  localparam int OFFSET_W    = $clog2(BLOCK_BYTES);
  localparam int ADDR_W      = 32;
  localparam int TAG_W       = ADDR_W - OFFSET_W;
  localparam int DATA_W      = 64;

  localparam int DEFAULT_ENTRIES = 4;

  localparam logic [7:0]        ERASED_BYTE  = 8'hFF;
  localparam logic [DATA_W-1:0] ERASED_BLOCK = {(DATA_W / 8){ERASED_BYTE}};

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // result kinds
  localparam logic RES_PROGRAM = 1'b0;
  localparam logic RES_DONE    = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [7:0]        byte_value;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [ADDR_W-1:0] block_address;
    logic [DATA_W-1:0] block_data;
    logic              last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_FLUSH,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch item, run the tag lookup
    logic update;      // merge or refill the selected entry
    logic flush_step;  // drain one entry
    logic emit_done;   // send the flush done beat
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_last;     // flush pointer on the final entry
  } ctrl_status_t;

endpackage

`default_nettype wire

// ----- hdl/fwcb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fwcb_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic                  item_kind,
  input  wire fwcb_pkg::ctrl_status_t status,
  output fwcb_pkg::ctrl_cmd_t        cmd,
  output logic                       busy
);

  fwcb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fwcb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      fwcb_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (item_kind == fwcb_pkg::KIND_FLUSH) begin
            state_nxt = fwcb_pkg::ST_FLUSH;
          end else begin
            state_nxt = fwcb_pkg::ST_UPDATE;
          end
        end
      end
      fwcb_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = fwcb_pkg::ST_IDLE;
      end
      fwcb_pkg::ST_FLUSH: begin
        cmd.flush_step = 1'b1;
        if (status.at_last) begin
          state_nxt = fwcb_pkg::ST_DONE;
        end
      end
      fwcb_pkg::ST_DONE: begin
        cmd.emit_done = 1'b1;
        state_nxt     = fwcb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fwcb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/fwcb_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fwcb_datapath #(
  parameter int ENTRIES = fwcb_pkg::DEFAULT_ENTRIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire fwcb_pkg::in_item_t    in_item,
  input  wire fwcb_pkg::ctrl_cmd_t   cmd,
  output fwcb_pkg::ctrl_status_t     status,
  output logic                       out_strobe,
  output fwcb_pkg::out_item_t        out_item
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic                               valid_r [ENTRIES];
  logic [fwcb_pkg::TAG_W-1:0]         tag_r   [ENTRIES];
  logic [fwcb_pkg::DATA_W-1:0]        bytes_r [ENTRIES];

  logic [IDX_W-1:0]                   victim_r;
  logic [IDX_W-1:0]                   sel_r;
  logic                               hit_r;
  fwcb_pkg::in_item_t                 item_r;

  logic                               strobe_r, strobe_nxt;
  fwcb_pkg::out_item_t                res_r, res_nxt;

  logic                               hit;
  logic [IDX_W-1:0]                   hit_idx;
  logic [fwcb_pkg::TAG_W-1:0]         in_tag;
  logic [fwcb_pkg::TAG_W-1:0]         item_tag;
  logic [fwcb_pkg::OFFSET_W+2:0]      bit_pos;
  logic [fwcb_pkg::DATA_W-1:0]        sel_bytes;
  logic [fwcb_pkg::DATA_W-1:0]        merged_hit;
  logic [fwcb_pkg::DATA_W-1:0]        merged_new;
  logic [IDX_W-1:0]                   victim_next;

  // parallel tag compare, lowest index wins
  assign in_tag = in_item.address[fwcb_pkg::ADDR_W-1:fwcb_pkg::OFFSET_W];

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (tag_r[i] == in_tag)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign item_tag    = item_r.address[fwcb_pkg::ADDR_W-1:fwcb_pkg::OFFSET_W];
  assign bit_pos     = {item_r.address[fwcb_pkg::OFFSET_W-1:0], 3'b000};
  assign sel_bytes   = bytes_r[sel_r];
  assign victim_next = (victim_r == LAST_IDX) ? '0 : victim_r + 1'b1;

  always_comb begin
    merged_hit                = sel_bytes;
    merged_hit[bit_pos +: 8]  = item_r.byte_value;
    merged_new                = fwcb_pkg::ERASED_BLOCK;
    merged_new[bit_pos +: 8]  = item_r.byte_value;
  end

  // result beat selection
  always_comb begin
    strobe_nxt            = 1'b0;
    res_nxt.result_kind   = fwcb_pkg::RES_PROGRAM;
    res_nxt.block_address = {tag_r[sel_r], {fwcb_pkg::OFFSET_W{1'b0}}};
    res_nxt.block_data    = sel_bytes;
    res_nxt.last          = 1'b0;
    if (cmd.update && !hit_r && valid_r[sel_r]) begin
      strobe_nxt   = 1'b1;
      res_nxt.last = 1'b1;
    end else if (cmd.flush_step && valid_r[sel_r]) begin
      strobe_nxt = 1'b1;
    end else if (cmd.emit_done) begin
      strobe_nxt            = 1'b1;
      res_nxt.result_kind   = fwcb_pkg::RES_DONE;
      res_nxt.block_address = '0;
      res_nxt.block_data    = '0;
      res_nxt.last          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
      victim_r <= '0;
      sel_r    <= '0;
      hit_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
      if (cmd.load) begin
        item_r <= in_item;
        hit_r  <= (in_item.kind == fwcb_pkg::KIND_WRITE) && hit;
        if (in_item.kind == fwcb_pkg::KIND_FLUSH) begin
          sel_r <= '0;
        end else if (hit) begin
          sel_r <= hit_idx;
        end else begin
          sel_r <= victim_r;
        end
      end
      if (cmd.update) begin
        if (hit_r) begin
          bytes_r[sel_r] <= merged_hit;
        end else begin
          victim_r       <= victim_next;
          valid_r[sel_r] <= 1'b1;
          tag_r[sel_r]   <= item_tag;
          bytes_r[sel_r] <= merged_new;
        end
      end
      if (cmd.flush_step) begin
        valid_r[sel_r] <= 1'b0;
        bytes_r[sel_r] <= fwcb_pkg::ERASED_BLOCK;
        sel_r          <= sel_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign status.at_last = (sel_r == LAST_IDX);
  assign out_strobe     = strobe_r;
  assign out_item       = res_r;

endmodule

`default_nettype wire

// ----- hdl/flash_write_combining_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// write: busy in the update state after the accept edge, so the next item waits for it;
//   a program request (victim eviction) is registered onto the result ports from the update state
// flush: busy through the flush sweep and the done state, one entry drained a cycle
//   by the flush pointer, done beat registered onto the ports from the done state
// the receiver cannot stall: every result beat stands for exactly one cycle
// synchronous active-low reset clears all valid bits, the victim pointer and the strobe

module flash_write_combining_buffer #(
  parameter int ENTRIES = fwcb_pkg::DEFAULT_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire fwcb_pkg::in_item_t in_item,
  output logic                    out_strobe,
  output fwcb_pkg::out_item_t     out_item
);

  // controller/datapath handshake
  fwcb_pkg::ctrl_cmd_t    cmd;
  fwcb_pkg::ctrl_status_t status;

  // sequencer: idle -> update for a write, idle -> flush sweep -> done for a flush
  fwcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item_kind (in_item.kind),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // entry array, tag lookup at accept, merge/refill, registered result beat
  fwcb_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .status     (status),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

// ----- hdl/fwcb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fwcb_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire fwcb_pkg::in_item_t  in_item,
  input wire logic                out_strobe,
  input wire fwcb_pkg::out_item_t out_item
);

  // strobe is dropped by reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result beat right after reset");

  // done beat carries zero payload and closes the item
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_item.result_kind == fwcb_pkg::RES_DONE) |->
      out_item.last && (out_item.block_address == '0) && (out_item.block_data == '0))
    else $error("malformed flush done beat");

  // program requests are block aligned
  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_item.result_kind == fwcb_pkg::RES_PROGRAM) |->
      (out_item.block_address[fwcb_pkg::OFFSET_W-1:0] == '0))
    else $error("unaligned program address");

  // an accepted item always occupies the block for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("not busy after accept");

endmodule

bind flash_write_combining_buffer fwcb_checker u_fwcb_checker (.*);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int N_ENTRIES = fwcb_pkg::DEFAULT_ENTRIES;
  localparam int N_RANDOM  = 420;
  localparam int POOL_SIZE = 8;
  localparam int TAG_W     = fwcb_pkg::TAG_W;
  localparam int OFFSET_W  = fwcb_pkg::OFFSET_W;

  // mirror of the combining buffer: predicts the program / done beats per item
  class program_scoreboard;
    bit                          ent_valid [N_ENTRIES];
    logic [TAG_W-1:0]            ent_tag   [N_ENTRIES];
    logic [fwcb_pkg::DATA_W-1:0] ent_bytes [N_ENTRIES];
    int unsigned                 victim;
    fwcb_pkg::out_item_t         beats_due [$];
    int                          errors;
    int                          n_writes, n_hits, n_evicts, n_flushes, n_beats;

    function new();
      for (int i = 0; i < N_ENTRIES; i++) begin
        ent_valid[i] = 1'b0;
        ent_tag[i]   = '0;
        ent_bytes[i] = fwcb_pkg::ERASED_BLOCK;
      end
      victim = 0;
    endfunction

    function automatic fwcb_pkg::out_item_t program_beat(int idx, logic is_last);
      fwcb_pkg::out_item_t b;
      b.result_kind   = fwcb_pkg::RES_PROGRAM;
      b.block_address = {ent_tag[idx], {OFFSET_W{1'b0}}};
      b.block_data    = ent_bytes[idx];
      b.last          = is_last;
      return b;
    endfunction

    function automatic void absorb_item(fwcb_pkg::in_item_t it);
      logic [TAG_W-1:0]    tag;
      logic [OFFSET_W-1:0] offs;
      int                  hit;
      int unsigned         v;
      fwcb_pkg::out_item_t done_beat;
      tag  = it.address[fwcb_pkg::ADDR_W-1:OFFSET_W];
      offs = it.address[OFFSET_W-1:0];
      hit  = -1;
      if (it.kind == fwcb_pkg::KIND_FLUSH) begin
        n_flushes++;
        // drain valid entries in index order, victim pointer untouched
        for (int i = 0; i < N_ENTRIES; i++) begin
          if (ent_valid[i]) begin
            beats_due.push_back(program_beat(i, 1'b0));
            ent_valid[i] = 1'b0;
            ent_bytes[i] = fwcb_pkg::ERASED_BLOCK;
          end
        end
        done_beat.result_kind   = fwcb_pkg::RES_DONE;
        done_beat.block_address = '0;
        done_beat.block_data    = '0;
        done_beat.last          = 1'b1;
        beats_due.push_back(done_beat);
        return;
      end
      n_writes++;
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (hit < 0 && ent_valid[i] && ent_tag[i] == tag) hit = i;
      end
      if (hit >= 0) begin
        n_hits++;
        ent_bytes[hit][offs*8 +: 8] = it.byte_value;
        return;
      end
      v      = (victim < N_ENTRIES) ? victim : 0;
      victim = (v + 1 >= N_ENTRIES) ? 0 : v + 1;
      if (ent_valid[v]) begin
        n_evicts++;
        beats_due.push_back(program_beat(v, 1'b1));
      end
      ent_valid[v] = 1'b1;
      ent_tag[v]   = tag;
      ent_bytes[v] = fwcb_pkg::ERASED_BLOCK;
      ent_bytes[v][offs*8 +: 8] = it.byte_value;
    endfunction

    function automatic void check_beat(fwcb_pkg::out_item_t got);
      fwcb_pkg::out_item_t want;
      n_beats++;
      if (beats_due.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      want = beats_due.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
        errors++;
      end
      if (got.block_address !== want.block_address) begin
        $error("block_address: expected %h, got %h", want.block_address,
               got.block_address);
        errors++;
      end
      if (got.block_data !== want.block_data) begin
        $error("block_data: expected %h, got %h", want.block_data, got.block_data);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return beats_due.size();
    endfunction

    function void report_leftover();
      if (beats_due.size() != 0) begin
        $error("%0d result beats never arrived", beats_due.size());
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  fwcb_pkg::in_item_t  in_item;
  logic                out_strobe;
  fwcb_pkg::out_item_t out_item;

  program_scoreboard board;

  // block tags that random writes mostly aim at, so hits and evictions both happen
  logic [TAG_W-1:0] tag_pool [POOL_SIZE];

  flash_write_combining_buffer #(
    .ENTRIES(N_ENTRIES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // safety net: far beyond the slowest legal run
  initial begin
    #400000;
    $display("** flash_write_combining_buffer: FAILED **");
    $finish;
  end

  // result side: the receiver cannot stall, so every strobed beat is taken
  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_beat(out_item);
  end

  // present one beat and hold it until an edge sees busy low
  task automatic send_item(input fwcb_pkg::in_item_t it);
    @(negedge clk);
    start   = 1'b1;
    in_item = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    board.absorb_item(it);
  endtask

  // sender gap: start held low, with junk on the payload that must be ignored
  task automatic sender_gap(input int n);
    if (n == 0) return;
    @(negedge clk);
    start   = 1'b0;
    in_item = {1'($urandom_range(0, 1)), 32'($urandom()), 8'($urandom_range(0, 255))};
    repeat (n - 1) @(negedge clk);
  endtask

  // hold off until every predicted beat has come back
  task automatic wait_drained();
    sender_gap(1);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_byte(input logic [fwcb_pkg::ADDR_W-1:0] addr,
                            input logic [7:0] val);
    fwcb_pkg::in_item_t it;
    it.kind       = fwcb_pkg::KIND_WRITE;
    it.address    = addr;
    it.byte_value = val;
    send_item(it);
  endtask

  task automatic flush_all();
    fwcb_pkg::in_item_t it;
    it.kind       = fwcb_pkg::KIND_FLUSH;
    it.address    = $urandom();
    it.byte_value = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [fwcb_pkg::ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      flush_all();
    end else begin
      if (pick < 20) addr = $urandom();
      else addr = {tag_pool[$urandom_range(0, 5)],
                   OFFSET_W'($urandom_range(0, fwcb_pkg::BLOCK_BYTES - 1))};
      write_byte(addr, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int burst;
    int sent;
    board   = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: block zero at both end offsets (hit at the top one), flush with one entry and with none
    write_byte(32'h0000_0000, 8'h00);
    write_byte(32'h0000_0007, 8'hFF);
    write_byte(32'h0000_0003, 8'hA5);
    flush_all();
    flush_all();
    // top of the address space, then fill every entry and force evictions
    write_byte(32'hFFFF_FFFF, 8'h5A);
    write_byte(32'hFFFF_FFF8, 8'h3C);
    write_byte(32'h5555_5555, 8'h55);
    write_byte(32'hAAAA_AAAA, 8'hAA);
    write_byte(32'h1234_5678, 8'h81);
    write_byte(32'h8000_0000, 8'h7E);
    write_byte(32'h0000_0010, 8'h01);
    write_byte(32'h5555_5551, 8'hC3);
    write_byte(32'h0000_0008, 8'h00);
    write_byte(32'hFFFF_FFF0, 8'hFF);
    // flush with all entries valid, back to back with a write into block zero
    flush_all();
    write_byte(32'h0000_0001, 8'h00);
    write_byte(32'h0000_0006, 8'h96);
    flush_all();
    wait_drained();

    // random part: bursts with gaps, mostly writes into a small set of blocks
    for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = TAG_W'($urandom());
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++) begin
        random_item();
        sent++;
      end
      // retire one block tag now and then so misses keep coming
      if ($urandom_range(0, 3) == 0)
        tag_pool[$urandom_range(0, POOL_SIZE - 1)] = TAG_W'($urandom());
      if (sent % 100 < burst) wait_drained();
      else if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(1, 6));
    end

    // final flush so every open entry is checked, then let the pipe settle
    flush_all();
    wait_drained();
    repeat (N_ENTRIES + 6) @(posedge clk);
    board.report_leftover();

    $display("run: %0d byte writes (%0d hits, %0d evictions), %0d flushes,",
             board.n_writes, board.n_hits, board.n_evicts, board.n_flushes);
    $display("     %0d result beats checked, %0d mismatches", board.n_beats, board.errors);
    if (board.errors == 0) begin
      $display("** flash_write_combining_buffer: PASSED **");
    end else begin
      $display("** flash_write_combining_buffer: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/fwcb_pkg.sv
hdl/fwcb_ctrl.sv
hdl/fwcb_datapath.sv
hdl/flash_write_combining_buffer.sv
hdl/fwcb_checker.sv
tb/sv/testbench.sv
